// ----- sv/ersd_pkg.sv -----
package ersd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic [9:0]  pos_z;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic signed [15:0] rot_w;
    logic [7:0]  shape_kind;
    logic [39:0] shape_dims;
    logic [23:0] color_rgb;
    logic [15:0] ident;
  } out_item_t;

  localparam logic [1:0] KIND_BODY   = 2'd0;
  localparam logic [1:0] KIND_CAMERA = 2'd1;
  localparam logic [1:0] KIND_UNKNOWN = 2'd2;
  localparam logic [1:0] KIND_TRUNC  = 2'd3;

  localparam logic [4:0] PH_TYPE  = 5'd0;
  localparam logic [4:0] PH_CAMID = 5'd1;
  localparam logic [4:0] PH_POS   = 5'd2;
  localparam logic [4:0] PH_IDX   = 5'd6;
  localparam logic [4:0] PH_QUAT  = 5'd7;
  localparam logic [4:0] PH_SHAPE = 5'd13;
  localparam logic [4:0] PH_COLOR = 5'd19;
  localparam logic [4:0] PH_ID    = 5'd22;
  localparam logic [4:0] PH_ID_HI = 5'd23;

  localparam logic signed [15:0] ONE_Q15 = 16'sd32767;
  localparam logic [31:0] FULL_SQ = 32'd1073676289; // 32767 squared

  localparam int QUEUE_DEPTH = 2;

  // Classified record handed from the parser to the finishing stage
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] position;
    logic [7:0]  axis;
    logic [47:0] comps;
    logic [47:0] shape;
    logic [23:0] color;
    logic [15:0] ident;
  } rec_t;

  typedef enum logic [1:0] {
    FIN_IDLE, FIN_SQUARE, FIN_ROOT, FIN_OUT
  } fin_state_t;

endpackage

// ----- sv/ersd_parser.sv -----
module ersd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ersd_pkg::in_item_t in_data,
  output logic              rec_valid,
  input  logic              rec_ready,
  output ersd_pkg::rec_t    rec_data
);
  import ersd_pkg::*;

  logic [4:0]  phase, phase_next;
  logic [7:0]  rtype, rtype_next;
  logic        discarding, discarding_next;
  logic [31:0] position, position_next;
  logic [7:0]  axis, axis_next;
  logic [47:0] comps, comps_next;
  logic [47:0] shape, shape_next;
  logic [23:0] color, color_next;
  logic [15:0] ident, ident_next;
  logic        emit;
  rec_t        emit_rec;
  logic [7:0]  b;
  logic        last;

  assign b    = in_data.data_byte;
  assign last = in_data.end_of_buffer;

  // Stall only when a record would be emitted and the queue is full
  assign in_ready  = rec_ready || !emit;
  assign rec_valid = in_valid && emit;
  assign rec_data  = emit_rec;

  always_comb begin
    logic done;
    logic [4:0] ph;
    done = 1'b0;
    ph = phase;
    emit = 1'b0;
    phase_next = phase;
    rtype_next = rtype;
    discarding_next = discarding;
    position_next = position;
    axis_next = axis;
    comps_next = comps;
    shape_next = shape;
    color_next = color;
    ident_next = ident;
    emit_rec = '0;
    if (discarding) begin
      if (last) discarding_next = 1'b0;
    end else begin
      if (phase == PH_CAMID) begin
        ident_next = {8'd0, b};
        ph = PH_POS;
      end else if (phase >= PH_POS && phase < PH_IDX) begin
        position_next[8*(phase - PH_POS) +: 8] = b;
        ph = phase + 5'd1;
      end else if (phase == PH_IDX) begin
        axis_next = b;
        if (b >= 8'd4 && b <= 8'd7) begin
          if (rtype == 8'd1) done = 1'b1;
          else ph = PH_SHAPE;
        end else begin
          ph = PH_QUAT;
        end
      end else if (phase >= PH_QUAT && phase < PH_SHAPE) begin
        comps_next[8*(phase - PH_QUAT) +: 8] = b;
        ph = phase + 5'd1;
        if (ph == PH_SHAPE && rtype == 8'd1) done = 1'b1;
      end else if (phase >= PH_SHAPE && phase < PH_COLOR) begin
        shape_next = {shape[39:0], b};
        ph = phase + 5'd1;
      end else if (phase >= PH_COLOR && phase < PH_ID) begin
        color_next = {color[15:0], b};
        ph = phase + 5'd1;
      end else if (phase == PH_ID) begin
        ident_next = {8'd0, b};
        ph = PH_ID_HI;
      end else if (phase == PH_ID_HI) begin
        ident_next = {b, ident[7:0]};
        done = 1'b1;
      end else begin
        rtype_next = b;
        position_next = '0;
        axis_next = '0;
        comps_next = '0;
        shape_next = '0;
        color_next = '0;
        ident_next = '0;
        if (b == 8'd0) ph = PH_POS;
        else if (b == 8'd1) ph = PH_CAMID;
        else ph = PH_TYPE;
      end

      if (phase > PH_ID_HI || phase == PH_TYPE) begin
        if (b > 8'd1) begin
          emit = 1'b1;
          emit_rec.kind = KIND_UNKNOWN;
          discarding_next = !last;
        end else if (last) begin
          emit = 1'b1;
          emit_rec.kind = KIND_TRUNC;
          ph = PH_TYPE;
        end
      end else if (done) begin
        emit = 1'b1;
        ph = PH_TYPE;
        emit_rec.kind = (rtype == 8'd1) ? KIND_CAMERA : KIND_BODY;
        emit_rec.position = position_next;
        emit_rec.axis = axis_next;
        emit_rec.comps = comps_next;
        emit_rec.shape = shape_next;
        emit_rec.color = color_next;
        emit_rec.ident = ident_next;
      end else if (last) begin
        emit = 1'b1;
        emit_rec.kind = KIND_TRUNC;
        ph = PH_TYPE;
      end
      phase_next = ph;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TYPE;
      discarding <= 1'b0;
      rtype <= '0;
      position <= '0;
      axis <= '0;
      comps <= '0;
      shape <= '0;
      color <= '0;
      ident <= '0;
    end else if (in_valid && in_ready) begin
      phase <= phase_next;
      discarding <= discarding_next;
      rtype <= rtype_next;
      position <= position_next;
      axis <= axis_next;
      comps <= comps_next;
      shape <= shape_next;
      color <= color_next;
      ident <= ident_next;
    end
  end

  a_disc_no_emit: assert property (@(posedge clk) disable iff (rst)
    discarding |-> !rec_valid) else $error("record emitted while discarding");
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= PH_ID_HI) else $error("phase out of range");
  a_disc_enter: assert property (@(posedge clk) disable iff (rst)
    $rose(discarding) |-> $past(rec_valid && rec_data.kind == KIND_UNKNOWN))
    else $error("discard entered without unknown-type record");
endmodule

// ----- sv/ersd_queue.sv -----
module ersd_queue #(
  parameter int DEPTH = ersd_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  ersd_pkg::rec_t  wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output ersd_pkg::rec_t  rd_data
);
  import ersd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  rec_t mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;
  logic wr_fire, rd_fire;

  assign wr_ready = (count != (AW+1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;
  assign rd_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_fire) mem[wptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr_fire) wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + AW'(1);
      if (rd_fire) rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + AW'(1);
      count <= count + (AW+1)'(wr_fire) - (AW+1)'(rd_fire);
    end
  end

  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH)) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (rst)
    count == '0 |=> !$past(rd_fire)) else $error("queue underflow");
  a_step: assert property (@(posedge clk) disable iff (rst)
    wr_fire && !rd_fire |=> count == $past(count) + (AW+1)'(1))
    else $error("queue count step");
endmodule

// ----- sv/ersd_finisher.sv -----
module ersd_finisher (
  input  logic               clk,
  input  logic               rst,
  input  logic               rec_valid,
  output logic               rec_ready,
  input  ersd_pkg::rec_t     rec_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ersd_pkg::out_item_t out_data
);
  import ersd_pkg::*;

  fin_state_t state, state_next;
  rec_t       rec;
  logic [31:0] sq_acc;
  logic        over;
  logic [1:0]  sq_cnt;
  logic [31:0] rem;
  logic [31:0] root;
  logic [31:0] bitv;
  logic [4:0]  rt_cnt;
  logic signed [15:0] comp;
  logic [31:0] sq;
  logic [32:0] acc_sum;
  logic signed [15:0] d, ca, cb, cc;
  logic [15:0] rounded;
  out_item_t   res;
  logic        unit_axis;

  assign unit_axis = rec.axis >= 8'd4 && rec.axis <= 8'd7;
  assign comp = rec.comps[16*sq_cnt +: 16];
  assign sq = 32'(comp * comp);
  assign acc_sum = {1'b0, sq_acc} + {1'b0, sq};

  always_comb begin
    state_next = state;
    rec_ready = 1'b0;
    case (state)
      FIN_IDLE: begin
        rec_ready = 1'b1;
        if (rec_valid) begin
          if (rec_data.kind[1] ||
              (rec_data.axis >= 8'd4 && rec_data.axis <= 8'd7))
            state_next = FIN_OUT;
          else state_next = FIN_SQUARE;
        end
      end
      FIN_SQUARE: if (sq_cnt == 2'd2) state_next = FIN_ROOT;
      FIN_ROOT:   if (rt_cnt == 5'd0) state_next = FIN_OUT;
      FIN_OUT:    if (out_ready) state_next = FIN_IDLE;
      default:    state_next = FIN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= FIN_IDLE;
    else state <= state_next;
  end

  // Bit-pair restoring root, one result bit a cycle
  always_ff @(posedge clk) begin
    case (state)
      FIN_IDLE: begin
        rec <= rec_data;
        sq_acc <= '0;
        over <= 1'b0;
        sq_cnt <= '0;
        root <= '0;
      end
      FIN_SQUARE: begin
        sq_acc <= acc_sum[31:0];
        if (acc_sum[32]) over <= 1'b1;
        sq_cnt <= sq_cnt + 2'd1;
        if (sq_cnt == 2'd2) begin
          if (over || acc_sum[32] || acc_sum[31:0] >= FULL_SQ) rem <= '0;
          else rem <= FULL_SQ - acc_sum[31:0];
          bitv <= 32'h4000_0000;
          rt_cnt <= 5'd15;
          root <= '0;
        end
      end
      FIN_ROOT: begin
        if (33'(rem) >= 33'(root) + 33'(bitv)) begin
          rem <= rem - (root + bitv);
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
        rt_cnt <= rt_cnt - 5'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    ca = rec.comps[15:0];
    cb = rec.comps[31:16];
    cc = rec.comps[47:32];
    rounded = (rem > root) ? root[15:0] + 16'd1 : root[15:0];
    d = signed'(rounded);
    res = '0;
    res.record_kind = rec.kind;
    if (!rec.kind[1]) begin
      res.pos_x = rec.position[31:22];
      res.pos_y = rec.position[21:12];
      res.pos_z = rec.position[9:0];
      if (unit_axis) begin
        case (rec.axis[1:0])
          2'd0: res.rot_x = ONE_Q15;
          2'd1: res.rot_y = ONE_Q15;
          2'd2: res.rot_z = ONE_Q15;
          default: res.rot_w = ONE_Q15;
        endcase
      end else if (rec.axis == 8'd0) begin
        res.rot_x = d; res.rot_y = ca; res.rot_z = cb; res.rot_w = cc;
      end else if (rec.axis == 8'd1) begin
        res.rot_x = ca; res.rot_y = d; res.rot_z = cb; res.rot_w = cc;
      end else if (rec.axis == 8'd2) begin
        res.rot_x = ca; res.rot_y = cb; res.rot_z = d; res.rot_w = cc;
      end else begin
        res.rot_x = ca; res.rot_y = cb; res.rot_z = cc; res.rot_w = d;
      end
      if (rec.kind == KIND_BODY) begin
        res.shape_kind = rec.shape[47:40];
        res.shape_dims = rec.shape[39:0];
        res.color_rgb = rec.color;
      end
      res.ident = rec.ident;
    end
  end

  assign out_valid = (state == FIN_OUT);
  assign out_data  = res;

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    rec_ready |-> state == FIN_IDLE) else $error("take while busy");
  a_root_len: assert property (@(posedge clk) disable iff (rst)
    state == FIN_ROOT && rt_cnt == 5'd0 |=> state == FIN_OUT)
    else $error("root did not finish");
  a_unit: assert property (@(posedge clk) disable iff (rst)
    state == FIN_SQUARE |-> !unit_axis) else $error("unit axis squared");
endmodule

// ----- sv/entity_record_stream_decoder.sv -----
// Channel | Dir | Handshake             | Payload
// in      | in  | in_valid / in_ready   | ersd_pkg::in_item_t  (data_byte, end_of_buffer)
// out     | out | out_valid / out_ready | ersd_pkg::out_item_t (decoded record)
//
// Bytes: one per cycle into the parser; the parser stalls only when a record
// would be queued while the record queue is full.
// Records: square sum of the three components, then the root (one bit a cycle), then
// held until taken; unit-axis, error and truncation records skip the arithmetic.
// Reset: synchronous, clears parser phase, queue pointers and finisher state.
// Stalls on out only back up the queue; bytes keep flowing until it fills.
module entity_record_stream_decoder #(
  parameter int QueueDepth = ersd_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ersd_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ersd_pkg::out_item_t out_data
);
  import ersd_pkg::*;

  // parser -> queue request
  logic p_valid, p_ready;
  rec_t p_data;
  // queue -> finisher request
  logic q_valid, q_ready;
  rec_t q_data;

  ersd_parser u_parser (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .rec_valid(p_valid), .rec_ready(p_ready), .rec_data(p_data)
  );

  ersd_queue #(.DEPTH(QueueDepth)) u_queue (
    .clk, .rst,
    .wr_valid(p_valid), .wr_ready(p_ready), .wr_data(p_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  ersd_finisher u_fin (
    .clk, .rst,
    .rec_valid(q_valid), .rec_ready(q_ready), .rec_data(q_data),
    .out_valid, .out_ready, .out_data
  );
endmodule

// ----- test/entity_record_stream_decoder_test.sv -----
`timescale 1ns / 100ps

module entity_record_stream_decoder_test;
  import ersd_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int N_RANDOM = 1350;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  entity_record_stream_decoder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Decoder mirror state
  logic [4:0]  dec_phase;
  logic [7:0]  dec_type;
  logic        dec_discard;
  logic [31:0] dec_pos;
  logic [7:0]  dec_axis;
  logic [47:0] dec_comps;
  logic [47:0] dec_shape;
  logic [23:0] dec_color;
  logic [15:0] dec_ident;

  out_item_t records_due[$];
  int failures;
  bit calm;   // long stretch with no idling

  function automatic logic [15:0] int_root(input longint unsigned s);
    longint unsigned r, bitv, rem;
    r = 0;
    bitv = 64'd1 << 30;
    rem = s;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= r + bitv) begin
        rem = rem - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    if (s - r * r > r) r++;
    return r[15:0];
  endfunction

  function automatic out_item_t blank_record(input logic [1:0] kind);
    out_item_t o;
    o = '0;
    o.record_kind = kind;
    return o;
  endfunction

  function automatic out_item_t finished_record();
    out_item_t o;
    logic signed [15:0] a, b, c, d;
    longint sum;
    o = blank_record(dec_type == 8'd1 ? KIND_CAMERA : KIND_BODY);
    o.pos_x = dec_pos[31:22];
    o.pos_y = dec_pos[21:12];
    o.pos_z = dec_pos[9:0];
    if (dec_axis >= 8'd4 && dec_axis <= 8'd7) begin
      case (dec_axis)
        8'd4: o.rot_x = ONE_Q15;
        8'd5: o.rot_y = ONE_Q15;
        8'd6: o.rot_z = ONE_Q15;
        default: o.rot_w = ONE_Q15;
      endcase
    end else begin
      a = dec_comps[15:0];
      b = dec_comps[31:16];
      c = dec_comps[47:32];
      sum = longint'(a) * a + longint'(b) * b + longint'(c) * c;
      // argument below zero clamps the root to 0
      d = (sum >= longint'(FULL_SQ)) ? 16'sd0 : int_root(longint'(FULL_SQ) - sum);
      case (dec_axis)
        8'd0: {o.rot_x, o.rot_y, o.rot_z, o.rot_w} = {d, a, b, c};
        8'd1: {o.rot_x, o.rot_y, o.rot_z, o.rot_w} = {a, d, b, c};
        8'd2: {o.rot_x, o.rot_y, o.rot_z, o.rot_w} = {a, b, d, c};
        default: {o.rot_x, o.rot_y, o.rot_z, o.rot_w} = {a, b, c, d};
      endcase
    end
    if (dec_type != 8'd1) begin
      o.shape_kind = dec_shape[47:40];
      o.shape_dims = dec_shape[39:0];
      o.color_rgb = dec_color;
    end
    o.ident = dec_ident;
    return o;
  endfunction

  // Advance the mirror by one accepted request; queue any record produced.
  task automatic decode_byte(input in_item_t it);
    logic [7:0] by;
    logic [4:0] ph;
    bit done;
    by = it.data_byte;
    ph = dec_phase;
    done = 0;
    if (dec_discard) begin
      if (it.end_of_buffer) dec_discard = 0;
      return;
    end
    if (ph == PH_CAMID) begin
      dec_ident = {8'd0, by};
      ph = PH_POS;
    end else if (ph >= PH_POS && ph < PH_IDX) begin
      dec_pos = dec_pos | (32'(by) << (8 * (ph - PH_POS)));
      ph++;
    end else if (ph == PH_IDX) begin
      dec_axis = by;
      if (by >= 8'd4 && by <= 8'd7) begin
        if (dec_type == 8'd1) done = 1;
        else ph = PH_SHAPE;
      end else begin
        ph = PH_QUAT;
      end
    end else if (ph >= PH_QUAT && ph < PH_SHAPE) begin
      dec_comps = dec_comps | (48'(by) << (8 * (ph - PH_QUAT)));
      ph++;
      if (ph == PH_SHAPE && dec_type == 8'd1) done = 1;
    end else if (ph >= PH_SHAPE && ph < PH_COLOR) begin
      dec_shape = {dec_shape[39:0], by};
      ph++;
    end else if (ph >= PH_COLOR && ph < PH_ID) begin
      dec_color = {dec_color[15:0], by};
      ph++;
    end else if (ph == PH_ID) begin
      dec_ident = {8'd0, by};
      ph++;
    end else if (ph == PH_ID_HI) begin
      dec_ident[15:8] = by;
      done = 1;
    end else begin
      dec_type = by;
      dec_pos = '0; dec_axis = '0; dec_comps = '0;
      dec_shape = '0; dec_color = '0; dec_ident = '0;
      if (by == 8'd0) ph = PH_POS;
      else if (by == 8'd1) ph = PH_CAMID;
      else begin
        // unknown type: flag it, then drop bytes to the buffer end
        dec_phase = PH_TYPE;
        dec_discard = !it.end_of_buffer;
        records_due.push_back(blank_record(KIND_UNKNOWN));
        return;
      end
    end
    if (done) begin
      dec_phase = PH_TYPE;
      records_due.push_back(finished_record());
    end else if (it.end_of_buffer) begin
      dec_phase = PH_TYPE;
      records_due.push_back(blank_record(KIND_TRUNC));
    end else begin
      dec_phase = ph;
    end
  endtask

  // Request list; a directed row may carry a hand-typed expectation.
  in_item_t requests[$];
  bit       has_fixed[$];
  out_item_t fixed_rec[$];
  // one entry per due record: typed-in expectation and whether it applies
  out_item_t hand_due[$];
  bit        hand_mark[$];

  task automatic add_byte(input logic [7:0] b, input bit eob);
    in_item_t it;
    it.data_byte = b;
    it.end_of_buffer = eob;
    requests.push_back(it);
    has_fixed.push_back(0);
    fixed_rec.push_back('0);
  endtask

  task automatic add_checked(input logic [7:0] b, input bit eob, input out_item_t e);
    add_byte(b, eob);
    has_fixed[$] = 1;
    fixed_rec[$] = e;
  endtask

  task automatic add_quat(input logic [7:0] idx, input logic [47:0] comps);
    add_byte(idx, 0);
    if (!(idx >= 8'd4 && idx <= 8'd7))
      for (int i = 0; i < 6; i++) add_byte(comps[8 * i +: 8], 0);
  endtask

  // Well-formed record with random content; may be cut short or end the buffer.
  task automatic add_random_record(input bit cut);
    logic [7:0] idx;
    logic [47:0] comps;
    int n0, limit;
    bit cam;
    n0 = requests.size();
    cam = $urandom_range(0, 2) == 0;
    case ($urandom_range(0, 5))
      0: idx = 8'($urandom_range(4, 7));
      1: idx = 8'($urandom);
      default: idx = 8'($urandom_range(0, 3));
    endcase
    comps = {$urandom, $urandom};
    if ($urandom_range(0, 2) != 0)
      comps = {16'($signed(15'($urandom)) >>> 1), 16'($signed(15'($urandom))),
               16'($signed(14'($urandom)))};
    add_byte(cam ? 8'd1 : 8'd0, 0);
    if (cam) add_byte(8'($urandom), 0);
    for (int i = 0; i < 4; i++) add_byte(8'($urandom), 0);
    add_quat(idx, comps);
    if (!cam)
      for (int i = 0; i < 11; i++) add_byte(8'($urandom), 0);
    if (cut) begin
      limit = $urandom_range(n0, requests.size() - 2);
      while (requests.size() > limit + 1) begin
        void'(requests.pop_back()); void'(has_fixed.pop_back()); void'(fixed_rec.pop_back());
      end
      requests[$].end_of_buffer = 1;
    end else if ($urandom_range(0, 3) == 0) begin
      requests[$].end_of_buffer = 1;
    end
  endtask

  task automatic build_directed();
    out_item_t e;
    // body, unit axis w, all-ones content
    add_byte(8'd0, 0);
    for (int i = 0; i < 4; i++) add_byte(8'hFF, 0);
    add_byte(8'd7, 0);
    for (int i = 0; i < 10; i++) add_byte(8'hFF, 0);
    e = '0;
    e.record_kind = KIND_BODY;
    e.pos_x = 10'h3FF; e.pos_y = 10'h3FF; e.pos_z = 10'h3FF;
    e.rot_w = ONE_Q15;
    e.shape_kind = 8'hFF; e.shape_dims = '1; e.color_rgb = '1; e.ident = 16'hFFFF;
    add_checked(8'hFF, 0, e);
    // camera, unit axis x, zero position
    add_byte(8'd1, 0);
    add_byte(8'h00, 0);
    for (int i = 0; i < 4; i++) add_byte(8'h00, 0);
    e = blank_record(KIND_CAMERA);
    e.rot_x = ONE_Q15;
    add_checked(8'd4, 0, e);
    // camera, index 0, root argument negative (components all most negative)
    add_byte(8'd1, 0); add_byte(8'h5A, 0);
    for (int i = 0; i < 4; i++) add_byte(8'($urandom), 0);
    add_quat(8'd0, {3{16'h8000}});
    // indices 1, 2, 3 and 255 with zero and mid components
    for (int k = 0; k < 4; k++) begin
      add_byte(8'd1, 0); add_byte(8'(k), 0);
      for (int i = 0; i < 4; i++) add_byte(8'($urandom), 0);
      add_quat(k == 3 ? 8'hFF : 8'(k + 1), k == 0 ? 48'd0 : {16'h4000, 16'hC000, 16'h2000});
    end
    // unknown type, discarded tail through the buffer end
    add_checked(8'hA5, 0, blank_record(KIND_UNKNOWN));
    add_byte(8'd0, 0); add_byte(8'd1, 1);
    // unknown type on the last byte
    add_checked(8'hFF, 1, blank_record(KIND_UNKNOWN));
    // truncated record
    add_byte(8'd0, 0);
    add_checked(8'h12, 1, blank_record(KIND_TRUNC));
    // type byte alone ending the buffer
    add_checked(8'd1, 1, blank_record(KIND_TRUNC));
  endtask

  // Producer side
  int req_idx;
  always @(posedge clk) begin
    int n_due;
    if (rst) begin
      in_valid <= 1'b0;
      req_idx <= 0;
    end else begin
      if (in_valid && in_ready) begin
        n_due = records_due.size();
        decode_byte(in_data);
        if (records_due.size() > n_due) begin
          hand_due.push_back(fixed_rec[req_idx - 1]);
          hand_mark.push_back(has_fixed[req_idx - 1]);
        end
      end
      if (!in_valid || in_ready) begin
        if (req_idx < requests.size() && (calm || $urandom_range(0, 99) >= 23)) begin
          in_valid <= 1'b1;
          in_data <= requests[req_idx];
          req_idx <= req_idx + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Consumer side and checking
  always @(posedge clk) begin
    out_item_t want;
    out_item_t typed;
    bit marked;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (records_due.size() == 0) begin
          $display("%0t: unexpected record %p", $time, out_data);
          failures++;
        end else begin
          want = records_due.pop_front();
          typed = hand_due.pop_front();
          marked = hand_mark.pop_front();
          if (want !== out_data) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_data);
            failures++;
          end
          // typed-in row must agree too
          if (marked && typed !== out_data) begin
            $display("%0t: mismatch expected %p actual %p", $time, typed, out_data);
            failures++;
          end
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 23);
    end
  end

  int quiet;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
  end

  initial begin
    failures = 0;
    calm = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    dec_phase = PH_TYPE; dec_type = '0; dec_discard = 0; dec_pos = '0; dec_axis = '0;
    dec_comps = '0; dec_shape = '0; dec_color = '0; dec_ident = '0;
    build_directed();
    while (requests.size() < N_RANDOM) begin
      if ($urandom_range(0, 9) < 7) add_random_record($urandom_range(0, 9) == 0);
      else if ($urandom_range(0, 1)) add_byte(8'($urandom), $urandom_range(0, 3) == 0);
      else add_byte(8'($urandom_range(2, 255)), 0);
    end
    requests[$].end_of_buffer = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    fork
      begin
        wait (req_idx >= 400);
        calm = 1;
        wait (req_idx >= 700);
        calm = 0;
      end
    join_none
    while (!(req_idx == requests.size() && !in_valid && records_due.size() == 0)
           && quiet < IDLE_LIMIT)
      @(posedge clk);
    if (quiet >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      repeat (40) @(posedge clk);
      if (records_due.size() != 0 || hand_due.size() != 0) failures++;
      if (failures == 0) begin
        $display("status: pass");
      end else begin
        $display("status: fail");
      end
      $finish;
    end
  end

endmodule
